// ----- src/smgs_pkg.sv -----
// ----------------------------------------------------------------------------
// smgs_pkg: shared types and constants of the stem mixer with gain slew.
// Holds the channel payloads, the command and register codes and the
// fixed-point widths that every stage agrees on.
// ----------------------------------------------------------------------------
package smgs_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int GAIN_BITS      = 15;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int STEM_IDX_BITS  = 3;
  localparam int MASK_BITS      = 8;
  localparam int COUNT_BITS     = 32;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 15;

  // Accumulators carry five guard bits above the sample width.
  localparam int ACC_BITS    = SAMPLE_BITS + 5;
  // Signed sample times zero-extended gain.
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  // Product after the floor shift by the gain fraction bits.
  localparam int SCALED_BITS = SAMPLE_BITS + GAIN_BITS - GAIN_FRAC_BITS + 1;

  localparam logic [GAIN_BITS-1:0]     UNITY_GAIN     = GAIN_BITS'(1 << GAIN_FRAC_BITS);
  localparam logic [MASK_BITS-1:0]     MASK_RESET     = '1;
  localparam logic [GAIN_BITS-1:0]     GAIN_STEP_RESET = GAIN_BITS'(1638);

  typedef enum logic [1:0] {
    CMD_SAMPLE,
    CMD_TARGET,
    CMD_EOF
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RUNNING,
    REG_STEM_MASK,
    REG_GAIN_STEP
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]                    cmd;
    logic [STEM_IDX_BITS-1:0]      stem_index;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic [GAIN_BITS-1:0]          target_level;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mix_left;
    logic signed [SAMPLE_BITS-1:0] mix_right;
    logic [COUNT_BITS-1:0]         frame_count;
  } out_item_t;

  // What the gain stage hands to the accumulator stage.
  typedef struct packed {
    logic                          mix;
    logic                          eof;
    logic signed [SCALED_BITS-1:0] scaled_left;
    logic signed [SCALED_BITS-1:0] scaled_right;
  } stage_t;

endpackage

// ----- src/stem_mixer_gain_slew.sv -----
// ----------------------------------------------------------------------------
// stem_mixer_gain_slew: stereo stem mixer with per-stem gain slew.
// An end of frame passes the input, gain stage and result registers to out_valid.
// Throughput: one transaction per cycle while no end-of-frame result is held up.
// Reset (synchronous, rst_n low): gains and targets unity, sums and count
// zero, playback stopped, all stems enabled, gain step 1638.
// ----------------------------------------------------------------------------
module stem_mixer_gain_slew #(
  parameter int NUM_STEMS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  smgs_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output smgs_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [smgs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [smgs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // The datapath has three register ranks: the input register, the
  // scaled-product register inside the gain stage and the result register.
  // The gain stage reads and updates the stem gain in the same cycle, so a
  // sample for a stem may follow another for the same stem directly.

  logic                              running_r;
  logic [smgs_pkg::MASK_BITS-1:0]    stem_mask_r;
  logic [smgs_pkg::GAIN_BITS-1:0]    gain_step_r;

  logic                              in_valid_r;
  smgs_pkg::in_item_t                in_r;
  logic                              stage_valid;
  smgs_pkg::stage_t                  stage;
  logic                              res_valid;
  smgs_pkg::out_item_t               res;
  logic                              out_valid_r;
  smgs_pkg::out_item_t               out_r;
  logic                              adv;

  // The pipeline only holds when an end-of-frame result is about to enter
  // a result register that is still waiting to be taken. Sample and target
  // transactions keep flowing past a waiting result.
  assign adv      = !(res_valid && out_valid_r && !out_ready);
  assign in_ready = adv;

  // Configuration registers. Write only while the block is idle; it is not enforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      stem_mask_r <= smgs_pkg::MASK_RESET;
      gain_step_r <= smgs_pkg::GAIN_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        smgs_pkg::REG_RUNNING:   running_r   <= cfg_data[0];
        smgs_pkg::REG_STEM_MASK: stem_mask_r <= cfg_data[smgs_pkg::MASK_BITS-1:0];
        smgs_pkg::REG_GAIN_STEP: gain_step_r <= cfg_data[smgs_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register: captures each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
    end
  end

  smgs_gain_stage #(
    .NUM_STEMS (NUM_STEMS)
  ) u_gain_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .item_valid    (in_valid_r),
    .item          (in_r),
    .running       (running_r),
    .stem_mask     (stem_mask_r),
    .gain_step     (gain_step_r),
    .stage_valid_r (stage_valid),
    .stage_r       (stage)
  );

  smgs_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .stage_valid (stage_valid),
    .stage       (stage),
    .running     (running_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register. When it is full and not taken, adv is low, so a new
  // result never overwrites a waiting one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/smgs_gain_stage.sv -----
// ----------------------------------------------------------------------------
// smgs_gain_stage: per-stem gain and target store, gain slew and scaling.
// Moves the addressed stem's gain one step toward its target, multiplies
// both samples by the new gain and registers the scaled products.
// ----------------------------------------------------------------------------
module smgs_gain_stage #(
  parameter int NUM_STEMS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              item_valid,
  input  smgs_pkg::in_item_t                item,
  input  logic                              running,
  input  logic [smgs_pkg::MASK_BITS-1:0]    stem_mask,
  input  logic [smgs_pkg::GAIN_BITS-1:0]    gain_step,
  output logic                              stage_valid_r,
  output smgs_pkg::stage_t                  stage_r
);

  localparam int IDX_W = (NUM_STEMS > 1) ? $clog2(NUM_STEMS) : 1;
  localparam int GB    = smgs_pkg::GAIN_BITS;

  logic [GB-1:0]                        gain_r   [NUM_STEMS];
  logic [GB-1:0]                        target_r [NUM_STEMS];
  logic [31:0]                          idx_wide;
  logic [IDX_W-1:0]                     addr;
  logic                                 idx_ok;
  logic                                 do_mix;
  logic                                 do_target;
  logic [GB-1:0]                        gain_cur;
  logic [GB-1:0]                        target_cur;
  logic [GB:0]                          gain_up;
  logic [GB:0]                          down_limit;
  logic [GB-1:0]                        gain_nxt;
  logic signed [smgs_pkg::PROD_BITS-1:0] prod_left;
  logic signed [smgs_pkg::PROD_BITS-1:0] prod_right;
  smgs_pkg::stage_t                     stage_nxt;

  assign idx_wide   = 32'(item.stem_index);
  assign addr       = idx_wide[IDX_W-1:0];
  assign idx_ok     = idx_wide < 32'(NUM_STEMS);
  assign do_mix     = item_valid && (item.cmd == smgs_pkg::CMD_SAMPLE) && running && idx_ok
                      && stem_mask[item.stem_index];
  assign do_target  = item_valid && (item.cmd == smgs_pkg::CMD_TARGET) && idx_ok;
  assign gain_cur   = gain_r[addr];
  assign target_cur = target_r[addr];
  assign gain_up    = {1'b0, gain_cur} + {1'b0, gain_step};
  assign down_limit = {1'b0, target_cur} + {1'b0, gain_step};

  // Slew one step toward the target without passing it.
  always_comb begin
    gain_nxt = gain_cur;
    if (gain_cur < target_cur) begin
      gain_nxt = (gain_up > {1'b0, target_cur}) ? target_cur : gain_up[GB-1:0];
    end else if (gain_cur > target_cur) begin
      gain_nxt = ({1'b0, gain_cur} >= down_limit) ? (gain_cur - gain_step) : target_cur;
    end
  end

  assign prod_left  = smgs_pkg::PROD_BITS'(item.left_sample * $signed({1'b0, gain_nxt}));
  assign prod_right = smgs_pkg::PROD_BITS'(item.right_sample * $signed({1'b0, gain_nxt}));

  // Taking the upper bits is an arithmetic shift, which floors.
  always_comb begin
    stage_nxt.mix          = do_mix;
    stage_nxt.eof          = item_valid && (item.cmd == smgs_pkg::CMD_EOF);
    stage_nxt.scaled_left  = prod_left[smgs_pkg::GAIN_FRAC_BITS +: smgs_pkg::SCALED_BITS];
    stage_nxt.scaled_right = prod_right[smgs_pkg::GAIN_FRAC_BITS +: smgs_pkg::SCALED_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STEMS; i++) begin
        gain_r[i]   <= smgs_pkg::UNITY_GAIN;
        target_r[i] <= smgs_pkg::UNITY_GAIN;
      end
    end else if (adv) begin
      if (do_mix) begin
        gain_r[addr] <= gain_nxt;
      end
      if (do_target) begin
        target_r[addr] <= item.target_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (adv) begin
      stage_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

// ----- src/smgs_accum.sv -----
// ----------------------------------------------------------------------------
// smgs_accum: frame accumulators and frame counter.
// Adds scaled samples with saturation and, at the end of a frame, forms
// the clamped mix, clears the sums and, while running, counts the frame.
// ----------------------------------------------------------------------------
module smgs_accum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               stage_valid,
  input  smgs_pkg::stage_t   stage,
  input  logic               running,
  output logic               res_valid,
  output smgs_pkg::out_item_t res
);

  localparam int AB = smgs_pkg::ACC_BITS;
  localparam int SB = smgs_pkg::SAMPLE_BITS;
  localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
  localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};
  localparam logic signed [AB-1:0] OUT_MAX = AB'({1'b0, {(SB-1){1'b1}}});
  localparam logic signed [AB-1:0] OUT_MIN = -OUT_MAX - AB'(1);

  logic signed [AB-1:0]                  acc_left_r;
  logic signed [AB-1:0]                  acc_right_r;
  logic signed [AB-1:0]                  acc_left_nxt;
  logic signed [AB-1:0]                  acc_right_nxt;
  logic [smgs_pkg::COUNT_BITS-1:0]       frame_cnt_r;
  logic [smgs_pkg::COUNT_BITS-1:0]       frame_cnt_nxt;
  logic signed [AB:0]                    sum_left;
  logic signed [AB:0]                    sum_right;
  logic signed [SB-1:0]                  clamp_left;
  logic signed [SB-1:0]                  clamp_right;

  assign sum_left  = {acc_left_r[AB-1], acc_left_r} + (AB+1)'(stage.scaled_left);
  assign sum_right = {acc_right_r[AB-1], acc_right_r} + (AB+1)'(stage.scaled_right);

  always_comb begin
    if (sum_left > $signed({ACC_MAX[AB-1], ACC_MAX})) begin
      acc_left_nxt = ACC_MAX;
    end else if (sum_left < $signed({ACC_MIN[AB-1], ACC_MIN})) begin
      acc_left_nxt = ACC_MIN;
    end else begin
      acc_left_nxt = sum_left[AB-1:0];
    end
    if (sum_right > $signed({ACC_MAX[AB-1], ACC_MAX})) begin
      acc_right_nxt = ACC_MAX;
    end else if (sum_right < $signed({ACC_MIN[AB-1], ACC_MIN})) begin
      acc_right_nxt = ACC_MIN;
    end else begin
      acc_right_nxt = sum_right[AB-1:0];
    end
  end

  always_comb begin
    if (acc_left_r > OUT_MAX) begin
      clamp_left = OUT_MAX[SB-1:0];
    end else if (acc_left_r < OUT_MIN) begin
      clamp_left = OUT_MIN[SB-1:0];
    end else begin
      clamp_left = acc_left_r[SB-1:0];
    end
    if (acc_right_r > OUT_MAX) begin
      clamp_right = OUT_MAX[SB-1:0];
    end else if (acc_right_r < OUT_MIN) begin
      clamp_right = OUT_MIN[SB-1:0];
    end else begin
      clamp_right = acc_right_r[SB-1:0];
    end
  end

  assign frame_cnt_nxt = running ? (frame_cnt_r + 1'b1) : frame_cnt_r;

  assign res_valid       = stage_valid && stage.eof;
  assign res.mix_left    = running ? clamp_left : '0;
  assign res.mix_right   = running ? clamp_right : '0;
  assign res.frame_count = frame_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_left_r  <= '0;
      acc_right_r <= '0;
      frame_cnt_r <= '0;
    end else if (adv && stage_valid) begin
      if (stage.eof) begin
        acc_left_r  <= '0;
        acc_right_r <= '0;
        frame_cnt_r <= frame_cnt_nxt;
      end else if (stage.mix) begin
        acc_left_r  <= acc_left_nxt;
        acc_right_r <= acc_right_nxt;
      end
    end
  end

endmodule
